>>> rtl/ffaa_pkg.sv
// Shared types and constants for the first-fit arena allocator.
package ffaa_pkg;

    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int REQ_W            = 12;
    localparam int OFS_W            = 12;
    localparam int STAT_W           = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_NULL     = 3'd3,
        ST_OUTSIDE  = 3'd4,
        ST_DFREE    = 3'd5
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [OFS_W-1:0]   offset;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_WNN,
        S_A_WCUR,
        S_A_WPREV,
        S_D_RD,
        S_D_CHK,
        S_O_RD,
        S_O_CHK,
        S_M_RDB,
        S_M_RDC,
        S_M_CALC,
        S_M_WB,
        S_M_WP,
        S_FIN
    } seq_state_t;

endpackage

>>> rtl/ffaa_hdr_mem.sv
// Block header store: size and link per header offset, one write and one registered read port.
module ffaa_hdr_mem
    import ffaa_pkg::*;
#(
    parameter int DEPTH = ARENA_BYTES_DEF,
    parameter int AW    = $clog2(ARENA_BYTES_DEF),
    parameter int LW    = $clog2(ARENA_BYTES_DEF) + 1
)
(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [LW-1:0]   wr_size,
    input  logic [LW-1:0]   wr_link,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output logic [LW-1:0]   rd_size,
    output logic [LW-1:0]   rd_link
);

    logic [2*LW-1:0] store_reg [DEPTH];
    logic [2*LW-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= {wr_size, wr_link};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= store_reg[rd_addr];
        end
    end

    assign rd_size = rd_reg[2*LW-1:LW];
    assign rd_link = rd_reg[LW-1:0];

endmodule

>>> rtl/ffaa_seq.sv
// Request sequencer: free-list walks, split, insertion and coalescing over the header store.
module ffaa_seq
    import ffaa_pkg::*;
#(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int AW           = $clog2(ARENA_BYTES_DEF),
    parameter int LW           = $clog2(ARENA_BYTES_DEF) + 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [OFS_W-1:0]    payload_offset,
    output logic                res_valid,
    output result_t             res,
    input  logic                res_take,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [LW-1:0]       wr_size,
    output logic [LW-1:0]       wr_link,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic [LW-1:0]       rd_size,
    input  logic [LW-1:0]       rd_link
);

    localparam int CW = ((LW > REQ_W) ? LW : REQ_W) + 2;
    localparam logic [LW-1:0] NONE    = LW'(ARENA_BYTES);
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);

    seq_state_t         state_reg, state_next;
    logic               ready_reg, ready_next;
    logic [LW-1:0]      head_reg, head_next;
    logic               mode_reg, mode_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [AW-1:0]      blk_reg, blk_next;
    logic [LW-1:0]      cur_reg, cur_next;
    logic [LW-1:0]      prev_reg, prev_next;
    logic [LW-1:0]      psize_reg, psize_next;
    logic [LW-1:0]      steps_reg, steps_next;
    logic [LW-1:0]      nxt_reg, nxt_next;
    logic [LW-1:0]      olink_reg, olink_next;
    logic [LW-1:0]      nn_reg, nn_next;
    logic [LW-1:0]      nsize_reg, nsize_next;
    logic [LW-1:0]      csize_reg, csize_next;
    logic [LW-1:0]      sb_reg, sb_next;
    status_t            status_reg, status_next;
    logic [OFS_W-1:0]   gofs_reg, gofs_next;

    logic [LW-1:0]      head_eff;
    logic [CW-1:0]      sz_c, req_c, cur_c, ptr_c, merged_b, merged_p;
    logic [LW-1:0]      link_n, blink;

    function automatic logic [LW-1:0] norm(input logic [LW-1:0] v);
        return (v >= NONE) ? NONE : v;
    endfunction

    function automatic logic [CW-1:0] sat(input logic [CW-1:0] v);
        return (v > ARENA_C) ? ARENA_C : v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            head_reg  <= NONE;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        req_reg    <= req_next;
        blk_reg    <= blk_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        psize_reg  <= psize_next;
        steps_reg  <= steps_next;
        nxt_reg    <= nxt_next;
        olink_reg  <= olink_next;
        nn_reg     <= nn_next;
        nsize_reg  <= nsize_next;
        csize_reg  <= csize_next;
        sb_reg     <= sb_next;
        status_reg <= status_next;
        gofs_reg   <= gofs_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        ready_next  = ready_reg;
        head_next   = head_reg;
        mode_next   = mode_reg;
        req_next    = req_reg;
        blk_next    = blk_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        psize_next  = psize_reg;
        steps_next  = steps_reg;
        nxt_next    = nxt_reg;
        olink_next  = olink_reg;
        nn_next     = nn_reg;
        nsize_next  = nsize_reg;
        csize_next  = csize_reg;
        sb_next     = sb_reg;
        status_next = status_reg;
        gofs_next   = gofs_reg;

        wr_en    = 1'b0;
        wr_addr  = cur_reg[AW-1:0];
        wr_size  = csize_reg;
        wr_link  = NONE;
        rd_en    = 1'b0;
        rd_addr  = cur_reg[AW-1:0];

        head_eff = ready_reg ? head_reg : '0;
        sz_c     = CW'(rd_size);
        req_c    = CW'(req_reg);
        cur_c    = CW'(cur_reg);
        ptr_c    = CW'(payload_offset);
        link_n   = norm(rd_link);
        merged_b = CW'(sb_reg);
        merged_p = CW'(psize_reg);
        blink    = cur_reg;

        in_stall  = (state_reg != S_IDLE);
        res_valid = (state_reg == S_FIN);
        res.status = status_reg;
        res.offset = gofs_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = mode;
                    req_next    = request_bytes;
                    steps_next  = '0;
                    prev_next   = NONE;
                    status_next = ST_OK;
                    gofs_next   = '0;
                    cur_next    = norm(head_eff);
                    if (!ready_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_size    = LW'(ARENA_BYTES - HEADER_BYTES);
                        wr_link    = NONE;
                        ready_next = 1'b1;
                        head_next  = '0;
                    end
                    if (!mode)
                    begin
                        if (request_bytes == '0)
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else if (payload_offset == '0)
                    begin
                        status_next = ST_NULL;
                        state_next  = S_FIN;
                    end
                    else if (ptr_c < HDR_C || ptr_c - HDR_C >= ARENA_C)
                    begin
                        status_next = ST_OUTSIDE;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        blk_next   = AW'(ptr_c - HDR_C);
                        state_next = S_D_RD;
                    end
                end
            end

            S_A_RD:
            begin
                if (cur_reg == NONE || steps_reg == NONE)
                begin
                    status_next = ST_NOSPACE;
                    state_next  = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_A_CHK;
                end
            end

            S_A_CHK:
            begin
                if (sz_c >= req_c)
                begin
                    olink_next = link_n;
                    nxt_next   = link_n;
                    csize_next = rd_size;
                    nn_next    = LW'(cur_c + HDR_C + req_c);
                    nsize_next = LW'(sz_c - req_c - HDR_C);
                    gofs_next  = OFS_W'(cur_c + HDR_C);
                    state_next = S_A_WCUR;
                    if (sz_c - req_c >= HDR_C && cur_c + HDR_C + req_c < ARENA_C)
                    begin
                        nxt_next   = LW'(cur_c + HDR_C + req_c);
                        csize_next = LW'(req_reg);
                        state_next = S_A_WNN;
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    psize_next = rd_size;
                    cur_next   = link_n;
                    state_next = S_A_RD;
                end
            end

            S_A_WNN:
            begin
                wr_en      = 1'b1;
                wr_addr    = nn_reg[AW-1:0];
                wr_size    = nsize_reg;
                wr_link    = olink_reg;
                state_next = S_A_WCUR;
            end

            S_A_WCUR:
            begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg[AW-1:0];
                wr_size    = csize_reg;
                wr_link    = NONE;
                state_next = S_A_WPREV;
            end

            S_A_WPREV:
            begin
                if (prev_reg == NONE)
                begin
                    head_next = nxt_reg;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg[AW-1:0];
                    wr_size = psize_reg;
                    wr_link = nxt_reg;
                end
                state_next = S_FIN;
            end

            S_D_RD:
            begin
                if (cur_reg == NONE || steps_reg == NONE)
                begin
                    cur_next   = norm(head_reg);
                    prev_next  = NONE;
                    steps_next = '0;
                    state_next = S_O_RD;
                end
                else if (cur_reg == LW'(blk_reg))
                begin
                    status_next = ST_DFREE;
                    state_next  = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_D_CHK;
                end
            end

            S_D_CHK:
            begin
                cur_next   = link_n;
                state_next = S_D_RD;
            end

            S_O_RD:
            begin
                if (cur_reg == NONE || cur_reg >= LW'(blk_reg) || steps_reg == NONE)
                begin
                    state_next = S_M_RDB;
                end
                else
                begin
                    rd_en      = 1'b1;
                    steps_next = steps_reg + 1'b1;
                    prev_next  = cur_reg;
                    state_next = S_O_CHK;
                end
            end

            S_O_CHK:
            begin
                psize_next = rd_size;
                cur_next   = link_n;
                state_next = S_O_RD;
            end

            S_M_RDB:
            begin
                rd_en      = 1'b1;
                rd_addr    = blk_reg;
                state_next = S_M_RDC;
            end

            S_M_RDC:
            begin
                sb_next    = rd_size;
                rd_en      = 1'b1;
                rd_addr    = cur_reg[AW-1:0];
                state_next = S_M_CALC;
            end

            S_M_CALC:
            begin
                if (cur_reg != NONE && CW'(blk_reg) + CW'(sb_reg) + HDR_C == cur_c)
                begin
                    merged_b = sat(CW'(sb_reg) + sz_c + HDR_C);
                    blink    = link_n;
                end
                sb_next    = LW'(merged_b);
                olink_next = blink;
                nxt_next   = LW'(blk_reg);
                if (prev_reg != NONE &&
                    CW'(prev_reg) + CW'(psize_reg) + HDR_C == CW'(blk_reg))
                begin
                    merged_p = sat(CW'(psize_reg) + merged_b + HDR_C);
                    nxt_next = blink;
                end
                psize_next = LW'(merged_p);
                state_next = S_M_WB;
            end

            S_M_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = blk_reg;
                wr_size    = sb_reg;
                wr_link    = olink_reg;
                state_next = S_M_WP;
            end

            S_M_WP:
            begin
                if (prev_reg == NONE)
                begin
                    head_next = LW'(blk_reg);
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg[AW-1:0];
                    wr_size = psize_reg;
                    wr_link = nxt_reg;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/first_fit_arena_allocator.sv
// First-fit arena allocator: request sequencer, header store and result register.
// Manages an arena of ARENA_BYTES bytes as an address-ordered free list of headers
// (HEADER_BYTES each, payload size plus link). mode 0 allocates request_bytes first-fit
// and returns the payload offset; mode 1 frees payload_offset, inserting it in address
// order and merging it with touching neighbours. Every request gives one result. The
// first request after reset sets up one free block spanning the whole arena; there is
// no clearing pass. All headers sit in one memory with one write port and one registered
// read port, and each visited free-list block costs a read state and a check state: an
// allocate walks the list once (with one more header write when the block is split), a
// free walks the whole list for a double free and then the blocks ahead of the freed one;
// rejected requests go straight to the result. A result waiting in the output register
// does not hold back the next request.
module first_fit_arena_allocator
    import ffaa_pkg::*;
#(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [OFS_W-1:0]    payload_offset,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STAT_W-1:0]   status,
    output logic [OFS_W-1:0]    granted_offset
);

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int LW = AW + 1;

    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [LW-1:0]      wr_size, wr_link, rd_size, rd_link;
    logic               res_valid, res_take;
    result_t            res;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;

    ffaa_seq #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .AW           (AW),
        .LW           (LW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .payload_offset (payload_offset),
        .res_valid      (res_valid),
        .res            (res),
        .res_take       (res_take),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_size        (wr_size),
        .wr_link        (wr_link),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_size        (rd_size),
        .rd_link        (rd_link)
    );

    ffaa_hdr_mem #(
        .DEPTH (ARENA_BYTES),
        .AW    (AW),
        .LW    (LW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_size (wr_size),
        .wr_link (wr_link),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_size (rd_size),
        .rd_link (rd_link)
    );

    always_comb
    begin
        res_take       = res_valid && (!out_valid_reg || !out_stall);
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
            res_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = res_reg.status;
    assign granted_offset = res_reg.offset;

`ifndef SYNTHESIS
    a_zero_offset_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_offset == '0)
        else $error("non-zero offset with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STAT_W'(ST_DFREE))
        else $error("status code out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("sequencer idle straight after a request");
`endif

endmodule

>>> tb/tb_top.sv
// Testbench for the first-fit arena allocator: directed and random requests checked against a free-list predictor.
`timescale 1ns / 1ps
module tb_top;
    import ffaa_pkg::*;

    localparam int ARENA   = 4096;
    localparam int HDR     = 16;
    localparam int NIL     = ARENA;
    localparam int N_RAND  = 2000;
    localparam int WD_MAX  = 200000;

    typedef struct packed {
        logic             mode;
        logic [REQ_W-1:0] bytes;
        logic [OFS_W-1:0] ofs;
    } request_t;

    logic clk, rst_n;
    logic in_valid, in_stall, mode, out_valid, out_stall;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFS_W-1:0]  payload_offset;
    logic [STAT_W-1:0] status;
    logic [OFS_W-1:0]  granted_offset;

    request_t pending_reqs[$];
    result_t  expected_results[$];
    int       live_blocks[$];
    int       fails = 0;
    int       wd = 0;
    bit       quiet = 0;
    int       in_gap = 0, out_gap = 0;

    // allocator state copy
    bit       ready_q;
    int       head_q;
    int       sz_q[ARENA];
    int       lk_q[ARENA];

    first_fit_arena_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .request_bytes(request_bytes), .payload_offset(payload_offset),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .granted_offset(granted_offset)
    );

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    function automatic int link_of(int a);
        int v;
        v = lk_q[a % ARENA];
        return (v < ARENA) ? v : NIL;
    endfunction

    function automatic int sat(int s);
        return (s > ARENA) ? ARENA : s;
    endfunction

    function automatic result_t predict_outcome(request_t r);
        result_t res;
        int cur, prv, steps, sz, nxt, nn, blk, ptr;
        res.status = ST_OK;
        res.offset = '0;
        if (!ready_q)
        begin
            sz_q[0] = ARENA - HDR;
            lk_q[0] = NIL;
            head_q = 0;
            ready_q = 1;
        end
        if (r.mode == 1'b0)
        begin
            if (r.bytes == 0)
            begin
                res.status = ST_ZERO;
                return res;
            end
            cur = (head_q < ARENA) ? head_q : NIL;
            prv = NIL;
            steps = 0;
            while (cur != NIL && steps < ARENA)
            begin
                sz = sz_q[cur];
                steps++;
                if (sz >= r.bytes)
                begin
                    nxt = link_of(cur);
                    if (sz - r.bytes >= HDR)
                    begin
                        nn = cur + HDR + r.bytes;
                        if (nn < ARENA)
                        begin
                            sz_q[nn] = sz - r.bytes - HDR;
                            lk_q[nn] = nxt;
                            sz_q[cur] = r.bytes;
                            nxt = nn;
                        end
                    end
                    if (prv == NIL)
                        head_q = nxt;
                    else
                        lk_q[prv] = nxt;
                    lk_q[cur] = NIL;
                    res.offset = OFS_W'(cur + HDR);
                    return res;
                end
                prv = cur;
                cur = link_of(cur);
            end
            res.status = ST_NOSPACE;
            return res;
        end
        ptr = r.ofs;
        if (ptr == 0)
        begin
            res.status = ST_NULL;
            return res;
        end
        if (ptr < HDR || ptr - HDR >= ARENA)
        begin
            res.status = ST_OUTSIDE;
            return res;
        end
        blk = ptr - HDR;
        cur = (head_q < ARENA) ? head_q : NIL;
        steps = 0;
        while (cur != NIL && steps < ARENA)
        begin
            if (cur == blk)
            begin
                res.status = ST_DFREE;
                return res;
            end
            steps++;
            cur = link_of(cur);
        end
        prv = NIL;
        cur = (head_q < ARENA) ? head_q : NIL;
        steps = 0;
        while (cur != NIL && cur < blk && steps < ARENA)
        begin
            steps++;
            prv = cur;
            cur = link_of(cur);
        end
        if (prv == NIL)
            head_q = blk;
        else
            lk_q[prv] = blk;
        lk_q[blk] = cur;
        if (cur != NIL && blk + sz_q[blk] + HDR == cur)
        begin
            sz_q[blk] = sat(sz_q[blk] + sz_q[cur] + HDR);
            lk_q[blk] = link_of(cur);
        end
        if (prv != NIL && prv + sz_q[prv] + HDR == blk)
        begin
            sz_q[prv] = sat(sz_q[prv] + sz_q[blk] + HDR);
            lk_q[prv] = link_of(blk);
        end
        return res;
    endfunction

    // queue a request, keeping track of granted offsets so frees stay legal
    task automatic add_request(logic m, int b, int o);
        request_t r;
        result_t  e;
        int       k;
        r.mode = m;
        r.bytes = b[REQ_W-1:0];
        r.ofs = o[OFS_W-1:0];
        e = predict_outcome(r);
        if (m == 1'b0 && e.status == ST_OK)
            live_blocks.push_back(e.offset);
        if (m == 1'b1 && e.status == ST_OK)
        begin
            for (k = 0; k < live_blocks.size(); k++)
            begin
                if (live_blocks[k] == o)
                begin
                    live_blocks.delete(k);
                    break;
                end
            end
        end
        pending_reqs.push_back(r);
        expected_results.push_back(e);
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= 1'b0;
            request_bytes <= '0;
            payload_offset <= '0;
            in_gap <= 0;
        end
        else if (in_valid && in_stall)
        begin
            // hold
        end
        else
        begin
            if (in_valid)
                void'(pending_reqs.pop_front());
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet && in_valid && $urandom_range(0, 15) == 0)
            begin
                in_gap <= $urandom_range(0, 9);
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_valid <= 1'b1;
                mode <= pending_reqs[0].mode;
                request_bytes <= pending_reqs[0].bytes;
                payload_offset <= pending_reqs[0].ofs;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else if (out_gap > 0)
            out_gap <= out_gap - 1;
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            out_stall <= 1'b1;
            out_gap <= $urandom_range(0, 9);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                wd <= 0;
            else
                wd <= wd + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result status=%0d granted_offset=%0d",
                           status, granted_offset);
                    fails++;
                end
                else
                begin
                    if (status !== expected_results[0].status)
                    begin
                        $error("status expected %0d actual %0d",
                               expected_results[0].status, status);
                        fails++;
                    end
                    if (granted_offset !== expected_results[0].offset)
                    begin
                        $error("granted_offset expected %0d actual %0d",
                               expected_results[0].offset, granted_offset);
                        fails++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (wd >= WD_MAX)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int i, k, sel;
        ready_q = 0;
        head_q = NIL;
        for (i = 0; i < ARENA; i++)
        begin
            sz_q[i] = 0;
            lk_q[i] = 0;
        end
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n = 1'b1;

        add_request(1'b1, 0, 0);
        add_request(1'b0, 0, 0);
        add_request(1'b1, 4095, 5);
        add_request(1'b1, 0, 15);
        add_request(1'b1, 0, 1);
        add_request(1'b1, 0, 16);
        add_request(1'b0, 1, 0);
        add_request(1'b0, 4095, 0);
        add_request(1'b0, 4080, 4095);
        add_request(1'b0, 4064, 0);
        add_request(1'b1, 0, 16);
        add_request(1'b1, 0, 16);
        add_request(1'b0, 4072, 0);
        add_request(1'b1, 0, 16);
        add_request(1'b0, 100, 0);
        add_request(1'b0, 200, 0);
        add_request(1'b0, 300, 0);
        add_request(1'b1, 0, 16);
        add_request(1'b1, 0, 16 + 100 + 16 + 200 + 16);
        add_request(1'b1, 0, 16 + 100 + 16);
        add_request(1'b0, 2048, 0);
        add_request(1'b0, 1, 0);

        for (i = 0; i < N_RAND; i++)
        begin
            if (i == N_RAND - 200)
                quiet = 1;
            sel = $urandom_range(0, 99);
            if (sel < 45)
                add_request(1'b0, $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                            : $urandom_range(1, 300), $urandom_range(0, 4095));
            else if (sel < 85 && live_blocks.size() > 0)
            begin
                k = $urandom_range(0, live_blocks.size() - 1);
                add_request(1'b1, $urandom_range(0, 4095), live_blocks[k]);
            end
            else if (sel < 92)
                add_request(1'b1, $urandom_range(0, 4095), $urandom_range(0, 15));
            else if (head_q < ARENA)
                add_request(1'b1, $urandom_range(0, 4095), head_q + HDR);
            else
                add_request(1'b0, $urandom_range(1, 4095), $urandom_range(0, 4095));
            while (pending_reqs.size() > 8)
                @(posedge clk);
        end
        // release everything so big merges happen
        while (live_blocks.size() > 0)
        begin
            k = $urandom_range(0, live_blocks.size() - 1);
            add_request(1'b1, 0, live_blocks[k]);
            while (pending_reqs.size() > 8)
                @(posedge clk);
        end
        add_request(1'b0, 4080, 0);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
